// ===== hw/rtl/decimal_token_to_binary_integer_macros.svh =====
// Assertion macros shared by the decimal token converter.
`ifndef DECIMAL_TOKEN_TO_BINARY_INTEGER_MACROS_SVH
`define DECIMAL_TOKEN_TO_BINARY_INTEGER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DTBI_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dtbi assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define DTBI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dtbi assertion failed");

`endif

// ===== hw/rtl/dtbi_pkg.sv =====
// Types and constants for the decimal token converter.
package dtbi_pkg;

  localparam int LEN_W = 6;
  localparam logic [LEN_W-1:0] LEN_MAX = 6'd63;
  localparam logic [LEN_W-1:0] TOKEN_LIMIT = 6'd28;

  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_PLUS = 8'd43;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_ZERO = 8'd48;
  localparam logic [7:0] CH_NINE = 8'd57;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_BAD  = 2'd1,
    ST_LONG = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    IT_I8  = 3'd0,
    IT_I16 = 3'd1,
    IT_I32 = 3'd2,
    IT_I64 = 3'd3,
    IT_U8  = 3'd4,
    IT_U16 = 3'd5,
    IT_U32 = 3'd6,
    IT_U64 = 3'd7
  } int_type_t;

  typedef struct packed {
    logic             in_token;
    logic [LEN_W-1:0] length;
    logic [63:0]      magnitude;
    logic             overflow;
    logic             negative;
    logic             digit_seen;
    logic             bad_char;
  } tok_t;

  typedef struct packed {
    logic [63:0] value;
    logic [1:0]  status;
  } result_t;

endpackage

// ===== hw/rtl/dtbi_text_if.sv =====
// Channel interface that carries one text byte or the end-of-stream mark.
interface dtbi_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       stream_end;

  modport source(output valid, output ch, output stream_end, input ready);
  modport sink(input valid, input ch, input stream_end, output ready);
endinterface

// ===== hw/rtl/dtbi_result_if.sv =====
// Channel interface that carries one converted value with its status.
interface dtbi_result_if;
  logic        valid;
  logic        ready;
  logic [63:0] value;
  logic [1:0]  status;

  modport source(output valid, output value, output status, input ready);
  modport sink(input valid, input value, input status, output ready);
endinterface

// ===== hw/rtl/dtbi_token_acc.sv =====
// Token state register with the per-byte decimal accumulate and flag update.
module dtbi_token_acc
  import dtbi_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] ch,
  input  logic       stream_end,
  output tok_t       tok,
  output logic       closing
);

  tok_t        tok_next;
  logic        is_space;
  logic        is_digit;
  logic [3:0]  digit;
  logic [67:0] product;

  assign is_space = stream_end || (ch <= CH_SPACE);
  assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign digit = 4'(ch - CH_ZERO);
  assign product = ({4'd0, tok.magnitude} << 3) + ({4'd0, tok.magnitude} << 1)
                   + {64'd0, digit};
  assign closing = is_space && tok.in_token;

  always_comb begin
    tok_next = tok;
    if (is_space) begin
      tok_next = '0;
    end else begin
      priority if (is_digit) begin
        tok_next.magnitude = product[63:0];
        tok_next.overflow = tok.overflow || (product[67:64] != 4'd0);
        tok_next.digit_seen = 1'b1;
      end else if ((tok.length == '0) && ((ch == CH_MINUS) || (ch == CH_PLUS))) begin
        tok_next.negative = (ch == CH_MINUS);
      end else begin
        tok_next.bad_char = 1'b1;
      end
      tok_next.in_token = 1'b1;
      if (tok.length != LEN_MAX) begin
        tok_next.length = tok.length + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok <= '0;
    end else if (step) begin
      tok <= tok_next;
    end
  end

endmodule

// ===== hw/rtl/dtbi_finish.sv =====
// Range check, sign application and status for a closed token.
module dtbi_finish
  import dtbi_pkg::*;
(
  input  tok_t      tok,
  input  int_type_t itype,
  output result_t   res
);

  logic [63:0] mask;
  logic [63:0] half;
  logic [63:0] limit;
  logic        is_unsigned;

  assign is_unsigned = itype[2];

  always_comb begin
    unique case (itype[1:0])
      2'd0: begin
        mask = 64'h0000_0000_0000_00FF;
        half = 64'h0000_0000_0000_0080;
      end
      2'd1: begin
        mask = 64'h0000_0000_0000_FFFF;
        half = 64'h0000_0000_0000_8000;
      end
      2'd2: begin
        mask = 64'h0000_0000_FFFF_FFFF;
        half = 64'h0000_0000_8000_0000;
      end
      default: begin
        mask = 64'hFFFF_FFFF_FFFF_FFFF;
        half = 64'h8000_0000_0000_0000;
      end
    endcase
  end

  always_comb begin
    priority if (is_unsigned) begin
      limit = mask;
    end else if (tok.negative) begin
      limit = half;
    end else begin
      limit = half - 64'd1;
    end
  end

  always_comb begin
    res.value = '0;
    priority if (tok.length >= TOKEN_LIMIT) begin
      res.status = ST_LONG;
    end else if (tok.bad_char || !tok.digit_seen || tok.overflow ||
                 (is_unsigned && tok.negative) || (tok.magnitude > limit)) begin
      res.status = ST_BAD;
    end else begin
      res.status = ST_OK;
      res.value = tok.negative ? ((64'd0 - tok.magnitude) & mask)
                               : (tok.magnitude & mask);
    end
  end

endmodule

// ===== hw/rtl/decimal_token_to_binary_integer.sv =====
// Top level of the decimal token to binary integer converter.
//
//   Channel   Kind       Contents
//   text      sink       ch, stream_end
//   result    source     value, status
//   cfg       write only cfg_we, cfg_wdata (integer type)
//
// One byte is taken per cycle unless a waiting result holds a closing byte; a
// closing byte passes the input register, then its result enters the output register.
// The token accumulator takes one multiply-by-ten add per cycle in which a byte advances.
// Reset clears the token state and the input and output valid flags, and sets the type to i32.
// A waiting result stalls a byte that closes a token, and the bytes behind it.
module decimal_token_to_binary_integer
  import dtbi_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [2:0] cfg_wdata,
  dtbi_text_if.sink  text,
  dtbi_result_if.source result
);

  `include "decimal_token_to_binary_integer_macros.svh"

  int_type_t  integer_type;
  logic       s1_valid;
  logic [7:0] s1_ch;
  logic       s1_end;
  logic       advance;
  logic       emit;
  logic       closing;
  tok_t       tok;
  result_t    fin;
  logic       out_valid;
  result_t    out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      integer_type <= IT_I32;
    end else if (cfg_we) begin
      integer_type <= int_type_t'(cfg_wdata);
    end
  end

  assign emit = s1_valid && closing;
  assign advance = s1_valid && (!emit || !out_valid || result.ready);
  assign text.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (text.ready) begin
      s1_valid <= text.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (text.ready && text.valid) begin
      s1_ch <= text.ch;
      s1_end <= text.stream_end;
    end
  end

  dtbi_token_acc u_acc (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .ch         (s1_ch),
    .stream_end (s1_end),
    .tok        (tok),
    .closing    (closing)
  );

  dtbi_finish u_finish (
    .tok   (tok),
    .itype (integer_type),
    .res   (fin)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && emit) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_data <= fin;
    end
  end

  assign result.valid = out_valid;
  assign result.value = out_data.value;
  assign result.status = out_data.status;

  // A failed transaction carries a zero value, and status code three never appears.
  `DTBI_ASSERT_NOW(a_status_code, out_valid, out_data.status != 2'd3)
  `DTBI_ASSERT_NOW(a_error_zero, out_valid && (out_data.status != ST_OK), out_data.value == '0)
  `DTBI_ASSERT_NEXT(a_close_clears, advance && emit, !tok.in_token && out_valid)

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// Testbench for the decimal token converter: directed tokens, then random token streams.
module tb;
  import dtbi_pkg::*;

  localparam int SETTLE_CYCLES = 4;
  localparam int RANDOM_BYTES = 1500;
  localparam int N_DIRECTED = 24;

  typedef struct {
    int_type_t   open_type;
    int_type_t   close_type;
    string       text;
    bit          at_end;
    logic [7:0]  term_ch;
    bit          typed;
    logic [63:0] value;
    status_t     status;
  } token_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_wdata = '0;

  dtbi_text_if text_ch();
  dtbi_result_if result_ch();

  decimal_token_to_binary_integer dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .text(text_ch),
    .result(result_ch)
  );

  always #10 clk = ~clk;

  int_type_t cur_type = IT_I32;
  logic tok_in = 1'b0;
  logic [LEN_W-1:0] tok_len = '0;
  logic [63:0] tok_mag = '0;
  logic tok_ovf = 1'b0;
  logic tok_neg = 1'b0;
  logic tok_digit = 1'b0;
  logic tok_bad = 1'b0;

  result_t awaited_results[$];
  result_t typed_result;
  bit typed_pending = 1'b0;
  int error_count = 0;
  int byte_count = 0;
  bit src_idle = 1'b0;
  bit sink_stalls = 1'b0;

  token_row_t dir_rows [N_DIRECTED] = '{
    '{IT_I32, IT_I32, "0", 1'b0, 8'd32, 1'b1, 64'd0, ST_OK},
    '{IT_I32, IT_I32, "2147483647", 1'b0, 8'd0, 1'b1, 64'h7FFF_FFFF, ST_OK},
    '{IT_I32, IT_I32, "-2147483648", 1'b1, 8'd0, 1'b1, 64'h8000_0000, ST_OK},
    '{IT_I32, IT_I32, "2147483648", 1'b0, 8'd9, 1'b1, 64'd0, ST_BAD},
    '{IT_I32, IT_I32, "", 1'b1, 8'd0, 1'b0, 64'd0, ST_OK},
    '{IT_I8, IT_I8, "-128", 1'b0, 8'd32, 1'b1, 64'h80, ST_OK},
    '{IT_I8, IT_I8, "+127", 1'b0, 8'd10, 1'b1, 64'h7F, ST_OK},
    '{IT_I8, IT_I8, "128", 1'b0, 8'd32, 1'b1, 64'd0, ST_BAD},
    '{IT_I8, IT_I8, "-129", 1'b0, 8'd32, 1'b0, 64'd0, ST_OK},
    '{IT_I16, IT_I16, "-32768", 1'b0, 8'd32, 1'b1, 64'h8000, ST_OK},
    '{IT_I16, IT_I16, "+", 1'b0, 8'd32, 1'b1, 64'd0, ST_BAD},
    '{IT_I64, IT_I64, "-9223372036854775808", 1'b0, 8'd32, 1'b1,
      64'h8000_0000_0000_0000, ST_OK},
    '{IT_I64, IT_I64, "9223372036854775807", 1'b1, 8'd0, 1'b1,
      64'h7FFF_FFFF_FFFF_FFFF, ST_OK},
    '{IT_U8, IT_U8, "255", 1'b0, 8'd32, 1'b1, 64'hFF, ST_OK},
    '{IT_U8, IT_U8, "-0", 1'b0, 8'd32, 1'b1, 64'd0, ST_BAD},
    '{IT_U16, IT_U16, "65535", 1'b0, 8'd32, 1'b1, 64'hFFFF, ST_OK},
    '{IT_U32, IT_U32, "4294967295", 1'b0, 8'd32, 1'b1, 64'hFFFF_FFFF, ST_OK},
    '{IT_U64, IT_U64, "18446744073709551615", 1'b0, 8'd32, 1'b1,
      64'hFFFF_FFFF_FFFF_FFFF, ST_OK},
    '{IT_U64, IT_U64, "18446744073709551616", 1'b0, 8'd32, 1'b1, 64'd0, ST_BAD},
    '{IT_U64, IT_U64, "1+2", 1'b0, 8'd32, 1'b1, 64'd0, ST_BAD},
    '{IT_U64, IT_U64, "7\377", 1'b0, 8'd32, 1'b1, 64'd0, ST_BAD},
    '{IT_I32, IT_I32, "000000000000000000000000001", 1'b0, 8'd32, 1'b1, 64'd1, ST_OK},
    '{IT_I32, IT_I32, "0000000000000000000000000001", 1'b0, 8'd32, 1'b1, 64'd0, ST_LONG},
    '{IT_I8, IT_U32, "300000", 1'b0, 8'd32, 1'b0, 64'd0, ST_OK}
  };

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [63:0] type_mask(input logic [2:0] t);
    int w;
    w = 8 << t[1:0];
    return (w == 64) ? 64'hFFFF_FFFF_FFFF_FFFF : ((64'd1 << w) - 64'd1);
  endfunction

  function automatic result_t convert_token();
    logic [2:0] t;
    logic [63:0] mask;
    logic [63:0] bound;
    result_t r;
    t = cur_type;
    mask = type_mask(t);
    if (t[2]) bound = mask;
    else if (tok_neg) bound = (mask >> 1) + 64'd1;
    else bound = mask >> 1;
    r.value = '0;
    r.status = ST_OK;
    if (tok_len >= TOKEN_LIMIT) begin
      r.status = ST_LONG;
    end else if (tok_bad || !tok_digit || tok_ovf || (t[2] && tok_neg) || tok_mag > bound) begin
      r.status = ST_BAD;
    end else begin
      r.value = tok_neg ? ((~tok_mag + 64'd1) & mask) : (tok_mag & mask);
    end
    return r;
  endfunction

  task automatic predict_byte(input logic [7:0] c, input logic e);
    logic [63:0] digit_val;
    if (e || c <= CH_SPACE) begin
      if (tok_in) begin
        if (typed_pending) begin
          awaited_results = {awaited_results, typed_result};
          typed_pending = 1'b0;
        end else begin
          awaited_results = {awaited_results, convert_token()};
        end
        tok_in = 1'b0;
        tok_len = '0;
        tok_mag = '0;
        tok_ovf = 1'b0;
        tok_neg = 1'b0;
        tok_digit = 1'b0;
        tok_bad = 1'b0;
      end
    end else begin
      if (c >= CH_ZERO && c <= CH_NINE) begin
        digit_val = 64'(c - CH_ZERO);
        if (tok_mag > (64'hFFFF_FFFF_FFFF_FFFF - digit_val) / 64'd10) tok_ovf = 1'b1;
        tok_mag = tok_mag * 64'd10 + digit_val;
        tok_digit = 1'b1;
      end else if (tok_len == '0 && (c == CH_MINUS || c == CH_PLUS)) begin
        tok_neg = (c == CH_MINUS);
      end else begin
        tok_bad = 1'b1;
      end
      tok_in = 1'b1;
      if (tok_len != LEN_MAX) tok_len = tok_len + 1'b1;
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("ERROR at %0t: %s", $realtime, what);
    error_count++;
  endtask

  task automatic check_result(input logic [63:0] value, input logic [1:0] status);
    result_t want;
    if (awaited_results.size() == 0) begin
      report_mismatch($sformatf("unexpected result value %h status %0d", value, status));
    end else begin
      want = awaited_results.pop_front();
      if (value !== want.value)
        report_mismatch($sformatf("value %h, wanted %h", value, want.value));
      if (status !== want.status)
        report_mismatch($sformatf("status %0d, wanted %0d", status, want.status));
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (text_ch.valid && text_ch.ready) predict_byte(text_ch.ch, text_ch.stream_end);
      if (result_ch.valid && result_ch.ready) check_result(result_ch.value, result_ch.status);
    end
  end

  initial begin
    int hold;
    hold = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
      end else if (sink_stalls && $urandom_range(0, 99) < 30) begin
        result_ch.ready = 1'b0;
        hold = pick_gap();
      end else begin
        result_ch.ready = 1'b1;
      end
    end
  end

  task automatic send_byte(input logic [7:0] c, input logic e);
    int gap;
    gap = src_idle ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      text_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    text_ch.valid = 1'b1;
    text_ch.ch = c;
    text_ch.stream_end = e;
    do @(posedge clk); while (!text_ch.ready);
  endtask

  task automatic settle();
    @(negedge clk);
    text_ch.valid = 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_type(input int_type_t t);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = t;
    cur_type = t;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic send_terminator();
    if ($urandom_range(0, 3) == 0) send_byte(8'($urandom), 1'b1);
    else send_byte(8'($urandom_range(0, 32)), 1'b0);
  endtask

  task automatic random_token();
    logic [7:0] tok[$];
    logic [63:0] mag;
    logic [2:0] t;
    string digits;
    int r;
    int n;
    int mid;
    r = $urandom_range(0, 99);
    t = cur_type;
    if (r < 35) begin
      case ($urandom_range(0, 3))
        0: tok = {tok, CH_MINUS};
        1: tok = {tok, CH_PLUS};
        default: ;
      endcase
      n = $urandom_range(0, 99);
      n = (n < 70) ? $urandom_range(1, 10) : (n < 95) ? $urandom_range(11, 21) :
          $urandom_range(22, 27);
      repeat (n) tok = {tok, 8'(CH_ZERO + 8'($urandom_range(0, 9)))};
    end else if (r < 70) begin
      if ($urandom_range(0, 1) == 1) begin
        mag = t[2] ? type_mask(t) : (type_mask(t) >> 1);
        if ($urandom_range(0, 2) == 0) tok = {tok, CH_PLUS};
      end else begin
        mag = (type_mask(t) >> 1) + 64'd1;
        tok = {tok, CH_MINUS};
      end
      mag = mag + 64'($urandom_range(0, 4)) - 64'd2;
      digits = $sformatf("%0d", mag);
      for (int i = 0; i < digits.len(); i++) tok = {tok, 8'(digits[i])};
    end else if (r < 88) begin
      n = $urandom_range(1, 8);
      repeat (n) begin
        case ($urandom_range(0, 2))
          0: tok = {tok, 8'(CH_ZERO + 8'($urandom_range(0, 9)))};
          1: tok = {tok, 8'(($urandom_range(0, 1) != 0) ? CH_MINUS : CH_PLUS)};
          default: tok = {tok, 8'($urandom_range(33, 255))};
        endcase
      end
    end else if (r < 96) begin
      n = $urandom_range(19, 27);
      repeat (n) tok = {tok, 8'(CH_ZERO + 8'($urandom_range(0, 9)))};
    end else begin
      n = $urandom_range(28, 70);
      repeat (n) begin
        if ($urandom_range(0, 4) == 0) tok = {tok, 8'($urandom_range(33, 255))};
        else tok = {tok, 8'(CH_ZERO + 8'($urandom_range(0, 9)))};
      end
    end
    mid = (tok.size() > 1 && $urandom_range(0, 24) == 0) ? $urandom_range(1, tok.size() - 1) : -1;
    for (int i = 0; i < tok.size(); i++) begin
      if (i == mid) begin
        settle();
        write_type(int_type_t'($urandom_range(0, 7)));
      end
      send_byte(tok[i], 1'b0);
      byte_count++;
    end
    send_terminator();
    byte_count++;
  endtask

  initial begin
    token_row_t row;
    int phase_left;
    text_ch.valid = 1'b0;
    text_ch.ch = '0;
    text_ch.stream_end = 1'b0;
    src_idle = 1'b1;
    sink_stalls = 1'b1;
    phase_left = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < N_DIRECTED; i++) begin
      row = dir_rows[i];
      if (row.open_type != cur_type) begin
        settle();
        write_type(row.open_type);
      end
      for (int k = 0; k < row.text.len(); k++) begin
        if (k == row.text.len() / 2 && row.close_type != cur_type) begin
          settle();
          write_type(row.close_type);
        end
        send_byte(row.text[k], 1'b0);
      end
      if (row.typed) begin
        typed_result.value = row.value;
        typed_result.status = row.status;
        typed_pending = 1'b1;
      end
      send_byte(row.at_end ? 8'($urandom) : row.term_ch, row.at_end);
    end

    while (byte_count < RANDOM_BYTES) begin
      if (phase_left == 0) begin
        phase_left = 30;
        src_idle = ($urandom_range(0, 3) != 0);
        sink_stalls = ($urandom_range(0, 3) != 0);
      end
      phase_left--;
      if ($urandom_range(0, 29) == 0) begin
        settle();
        write_type(int_type_t'($urandom_range(0, 7)));
      end
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 3)) send_terminator();
      end
      random_token();
    end

    @(negedge clk);
    text_ch.valid = 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #25_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
